>>> hw/rtl/unix_seconds_to_calendar_assert.svh
// Assertion macros used by the calendar converter back half (usc_back).
`ifndef UNIX_SECONDS_TO_CALENDAR_ASSERT_SVH
`define UNIX_SECONDS_TO_CALENDAR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("usc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define USC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("usc assertion failed");

`endif

>>> hw/rtl/usc_pkg.sv
// Types, constants and tables of the calendar converter.
`timescale 1ns / 1ps

package usc_pkg;

  localparam logic signed [33:0] WindowStart  = 34'sd1546300800;
  localparam logic signed [33:0] WindowEnd    = 34'sd4102444800;
  localparam logic signed [33:0] SecsPerHourS = 34'sd3600;
  localparam logic [31:0]        WindowStartU = 32'd1546300800;
  localparam logic [31:0]        SecsPerDay   = 32'd86400;
  localparam logic [16:0]        SecsPerHour  = 17'd3600;
  localparam logic [15:0]        DaysPerCycle = 16'd1461;
  localparam logic [14:0]        DaysToWindow = 15'd730;
  localparam logic [11:0]        BaseYear     = 12'd2017;

  // Reciprocals for constant division: q = (x * Recip) >> Shift.
  localparam logic [25:0] DayRecip   = 26'd50903317;  // / 675, after >> 7
  localparam int          DayShift   = 35;
  localparam logic [15:0] CycRecip   = 16'd45934;     // / 1461
  localparam int          CycShift   = 26;
  localparam logic [12:0] HourRecip  = 13'd4661;      // / 225, after >> 4
  localparam int          HourShift  = 20;
  localparam logic [10:0] MinRecip   = 11'd1093;      // / 15, after >> 2
  localparam int          MinShift   = 14;
  localparam logic [15:0] WkRecip    = 16'd37450;     // / 7
  localparam int          WkShift    = 18;

  // Register indexes on the configuration port.
  localparam logic RegZone   = 1'b0;
  localparam logic RegFormat = 1'b1;

  typedef struct packed {
    logic signed [4:0] zone_offset_hours;
    logic              hour_format_24;
  } usc_cfg_t;

  // Word handed from the front half to the back half of the pipeline.
  typedef struct packed {
    logic        oor;
    logic [4:0]  cycle;
    logic [4:0]  h24;
    logic [12:0] wq;
    logic [14:0] d;
    logic [16:0] sod;
    logic [14:0] wdx;
  } usc_front_t;

  // First day offset of each month in a common year; index 12 is the year length.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd365;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/usc_in_if.sv
// Input channel: one UTC seconds word per handshake.
`timescale 1ns / 1ps

interface usc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

>>> hw/rtl/usc_out_if.sv
// Output channel: one local calendar word per handshake.
`timescale 1ns / 1ps

interface usc_out_if;
  logic        valid;
  logic        ready;
  logic        out_of_range;
  logic [11:0] year;
  logic [8:0]  day_of_year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  logic [4:0]  hour_value;
  logic        is_pm;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output out_of_range, output year, output day_of_year,
                  output month, output day_of_month, output weekday, output hour_value,
                  output is_pm, output minute, output second, input ready);
  modport sink   (input valid, input out_of_range, input year, input day_of_year,
                  input month, input day_of_month, input weekday, input hour_value,
                  input is_pm, input minute, input second, output ready);
endinterface

>>> hw/rtl/usc_apb_regs.sv
// APB configuration registers: zone offset and hour format.
`timescale 1ns / 1ps

module usc_apb_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output usc_pkg::usc_cfg_t   cfg_o
);

  logic signed [4:0] zone_q;
  logic              fmt_q;
  logic              wr_en;

  // Register select is paddr[2]; the low address bits are not decoded.
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= 5'sd0;
      fmt_q  <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[2])
        usc_pkg::RegZone:   zone_q <= pwdata[4:0];
        usc_pkg::RegFormat: fmt_q  <= pwdata[0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[2])
      usc_pkg::RegZone:   prdata = {27'd0, zone_q};
      usc_pkg::RegFormat: prdata = {31'd0, fmt_q};
      default:            prdata = 32'd0;
    endcase
    if (paddr[1:0] != 2'b00) begin
      prdata = prdata;
    end
  end

  assign cfg_o.zone_offset_hours = zone_q;
  assign cfg_o.hour_format_24    = fmt_q;

endmodule

>>> hw/rtl/usc_front.sv
// Front half: zone offset, window check, day / second split and quotients.
`timescale 1ns / 1ps

module usc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  usc_pkg::usc_cfg_t    cfg_i,
  usc_in_if.sink               in_i,
  output logic                 front_valid_o,
  output usc_pkg::usc_front_t  front_data_o,
  input  logic                 front_ready_i
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: local time and window check
  logic signed [33:0] zone_ext;
  logic signed [33:0] local_t;
  logic               oor1_d, oor1_q;
  logic [31:0]        s1_d, s1_q;

  // Stage 2: days = s / 86400
  logic [50:0] day_prod;
  logic        oor2_q;
  logic [14:0] days2_d, days2_q;
  logic [31:0] s2_q;

  // Stage 3: second of day, cycle day, weekday dividend
  logic [31:0] day_secs;
  logic        oor3_q;
  logic [16:0] sod3_d, sod3_q;
  logic [14:0] d3_d, d3_q;
  logic [14:0] wdx3_d, wdx3_q;

  // Stage 4: quotients for cycle, hour and weekday
  logic [30:0] cyc_prod;
  logic [25:0] hour_prod;
  logic [30:0] wk_prod;
  usc_pkg::usc_front_t f4_d, f4_q;

  assign rdy4 = !v4_q || front_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_comb begin
    zone_ext = {{29{cfg_i.zone_offset_hours[4]}}, cfg_i.zone_offset_hours};
    local_t  = $signed({2'b00, in_i.unix_seconds}) + zone_ext * usc_pkg::SecsPerHourS;
    oor1_d   = (local_t < usc_pkg::WindowStart) || (local_t >= usc_pkg::WindowEnd);
    s1_d     = local_t[31:0] - usc_pkg::WindowStartU;
  end

  always_comb begin
    day_prod = {26'd0, s1_q[31:7]} * {25'd0, usc_pkg::DayRecip};
    days2_d  = day_prod[usc_pkg::DayShift +: 15];
  end

  always_comb begin
    day_secs = {17'd0, days2_q} * usc_pkg::SecsPerDay;
    sod3_d   = 17'(s2_q - day_secs);
    d3_d     = days2_q + usc_pkg::DaysToWindow;
    wdx3_d   = days2_q + 15'd1;
  end

  always_comb begin
    cyc_prod  = {16'd0, d3_q} * {15'd0, usc_pkg::CycRecip};
    hour_prod = {13'd0, sod3_q[16:4]} * {13'd0, usc_pkg::HourRecip};
    wk_prod   = {16'd0, wdx3_q} * {15'd0, usc_pkg::WkRecip};
    f4_d.oor   = oor3_q;
    f4_d.cycle = cyc_prod[usc_pkg::CycShift +: 5];
    f4_d.h24   = hour_prod[usc_pkg::HourShift +: 5];
    f4_d.wq    = wk_prod[usc_pkg::WkShift +: 13];
    f4_d.d     = d3_q;
    f4_d.sod   = sod3_q;
    f4_d.wdx   = wdx3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      oor1_q <= oor1_d;
      s1_q   <= s1_d;
    end
    if (rdy2 && v1_q) begin
      oor2_q  <= oor1_q;
      days2_q <= days2_d;
      s2_q    <= s1_q;
    end
    if (rdy3 && v2_q) begin
      oor3_q <= oor2_q;
      sod3_q <= sod3_d;
      d3_q   <= d3_d;
      wdx3_q <= wdx3_d;
    end
    if (rdy4 && v3_q) begin
      f4_q <= f4_d;
    end
  end

  assign front_valid_o = v4_q;
  assign front_data_o  = f4_q;

endmodule

>>> hw/rtl/usc_back.sv
// Back half: year split, month search, hour / minute / second and output register.
`timescale 1ns / 1ps

`include "unix_seconds_to_calendar_assert.svh"

module usc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  usc_pkg::usc_cfg_t    cfg_i,
  input  logic                 front_valid_i,
  input  usc_pkg::usc_front_t  front_data_i,
  output logic                 front_ready_o,
  usc_out_if.source            out_o
);

  logic v5_q, v6_q, v7_q, v8_q;
  logic rdy5, rdy6, rdy7, rdy8;

  // Stage 5: remainders
  logic [15:0] cyc_days;
  logic [15:0] r_full;
  logic [16:0] hour_secs;
  logic [16:0] remh_full;
  logic [15:0] wk_mul;
  logic [15:0] wd_full;
  logic        oor5_q;
  logic [4:0]  cycle5_q, h24_5_q;
  logic [10:0] r5_d, r5_q;
  logic [11:0] remh5_d, remh5_q;
  logic [2:0]  wd5_d, wd5_q;

  // Stage 6: year, day of year, minute
  logic [1:0]  yi;
  logic [10:0] yi_base;
  logic [10:0] doy_full;
  logic [20:0] min_prod;
  logic        oor6_q, leap6_q;
  logic [11:0] year6_d, year6_q;
  logic [8:0]  doy6_d, doy6_q;
  logic [5:0]  min6_d, min6_q;
  logic [11:0] remh6_q;
  logic [4:0]  h24_6_q;
  logic [2:0]  wd6_q;

  // Stage 7: month, second, hour format
  logic [3:0]  cnt;
  logic [3:0]  mon7_d, mon7_q;
  logic [8:0]  adj7_d, adj7_q;
  logic [11:0] min_secs;
  logic [5:0]  sec7_d, sec7_q;
  logic [4:0]  hv7_d, hv7_q;
  logic        pm7_d, pm7_q;
  logic        oor7_q;
  logic [11:0] year7_q;
  logic [8:0]  doy7_q;
  logic [5:0]  min7_q;
  logic [2:0]  wd7_q;

  // Stage 8: day of month and output word
  logic [8:0]  dom_full;
  logic        oor8_q;
  logic [11:0] year8_q;
  logic [8:0]  doy8_q;
  logic [3:0]  mon8_q;
  logic [4:0]  dom8_q;
  logic [2:0]  wd8_q;
  logic [4:0]  hv8_q;
  logic        pm8_q;
  logic [5:0]  min8_q;
  logic [5:0]  sec8_q;

  assign rdy8 = !v8_q || out_o.ready;
  assign rdy7 = !v7_q || rdy8;
  assign rdy6 = !v6_q || rdy7;
  assign rdy5 = !v5_q || rdy6;
  assign front_ready_o = rdy5;

  always_comb begin
    cyc_days  = {11'd0, front_data_i.cycle} * usc_pkg::DaysPerCycle;
    r_full    = {1'b0, front_data_i.d} - cyc_days;
    r5_d      = r_full[10:0];
    hour_secs = {12'd0, front_data_i.h24} * usc_pkg::SecsPerHour;
    remh_full = front_data_i.sod - hour_secs;
    remh5_d   = remh_full[11:0];
    wk_mul    = {3'd0, front_data_i.wq} * 16'd7;
    wd_full   = {1'b0, front_data_i.wdx} - wk_mul;
    wd5_d     = wd_full[2:0];
  end

  always_comb begin
    if (r5_q < 11'd365) begin
      yi = 2'd0;
    end else if (r5_q < 11'd730) begin
      yi = 2'd1;
    end else if (r5_q < 11'd1095) begin
      yi = 2'd2;
    end else begin
      yi = 2'd3;
    end
    case (yi)
      2'd0:    yi_base = 11'd0;
      2'd1:    yi_base = 11'd365;
      2'd2:    yi_base = 11'd730;
      default: yi_base = 11'd1095;
    endcase
    doy_full = r5_q - yi_base + 11'd1;
    doy6_d   = doy_full[8:0];
    year6_d  = usc_pkg::BaseYear + {5'd0, cycle5_q, 2'b00} + {10'd0, yi};
    min_prod = {11'd0, remh5_q[11:2]} * {10'd0, usc_pkg::MinRecip};
    min6_d   = min_prod[usc_pkg::MinShift +: 6];
  end

  // Month and its adjusted ordinal; day of month is taken in the next stage.
  always_comb begin
    cnt    = 4'd0;
    adj7_d = doy6_q;
    mon7_d = 4'd1;
    if (doy6_q <= 9'd31) begin
      mon7_d = 4'd1;
    end else if (doy6_q <= (leap6_q ? 9'd60 : 9'd59)) begin
      mon7_d = 4'd2;
    end else begin
      adj7_d = leap6_q ? doy6_q - 9'd1 : doy6_q;
      for (int j = 3; j < 12; j++) begin
        cnt = cnt + {3'd0, adj7_d > usc_pkg::month_start(4'(j))};
      end
      mon7_d = 4'd3 + cnt;
    end
    min_secs = {6'd0, min6_q} * 12'd60;
    sec7_d   = 6'(remh6_q - min_secs);
    pm7_d    = h24_6_q >= 5'd12;
    if (cfg_i.hour_format_24) begin
      hv7_d = h24_6_q;
    end else if (h24_6_q == 5'd0) begin
      hv7_d = 5'd12;
    end else if (h24_6_q <= 5'd12) begin
      hv7_d = h24_6_q;
    end else begin
      hv7_d = h24_6_q - 5'd12;
    end
  end

  assign dom_full = adj7_q - usc_pkg::month_start(mon7_q - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (rdy5) v5_q <= front_valid_i;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
      if (rdy8) v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && front_valid_i) begin
      oor5_q   <= front_data_i.oor;
      cycle5_q <= front_data_i.cycle;
      h24_5_q  <= front_data_i.h24;
      r5_q     <= r5_d;
      remh5_q  <= remh5_d;
      wd5_q    <= wd5_d;
    end
    if (rdy6 && v5_q) begin
      oor6_q  <= oor5_q;
      leap6_q <= (yi == 2'd3);
      year6_q <= year6_d;
      doy6_q  <= doy6_d;
      min6_q  <= min6_d;
      remh6_q <= remh5_q;
      h24_6_q <= h24_5_q;
      wd6_q   <= wd5_q;
    end
    if (rdy7 && v6_q) begin
      oor7_q  <= oor6_q;
      mon7_q  <= mon7_d;
      adj7_q  <= adj7_d;
      sec7_q  <= sec7_d;
      hv7_q   <= hv7_d;
      pm7_q   <= pm7_d;
      year7_q <= year6_q;
      doy7_q  <= doy6_q;
      min7_q  <= min6_q;
      wd7_q   <= wd6_q;
    end
    // Out-of-window words carry zeros in every field but the flag.
    if (rdy8 && v7_q) begin
      oor8_q  <= oor7_q;
      year8_q <= oor7_q ? 12'd0 : year7_q;
      doy8_q  <= oor7_q ? 9'd0  : doy7_q;
      mon8_q  <= oor7_q ? 4'd0  : mon7_q;
      dom8_q  <= oor7_q ? 5'd0  : dom_full[4:0];
      wd8_q   <= oor7_q ? 3'd0  : wd7_q;
      hv8_q   <= oor7_q ? 5'd0  : hv7_q;
      pm8_q   <= oor7_q ? 1'b0  : pm7_q;
      min8_q  <= oor7_q ? 6'd0  : min7_q;
      sec8_q  <= oor7_q ? 6'd0  : sec7_q;
    end
  end

  assign out_o.valid        = v8_q;
  assign out_o.out_of_range = oor8_q;
  assign out_o.year         = year8_q;
  assign out_o.day_of_year  = doy8_q;
  assign out_o.month        = mon8_q;
  assign out_o.day_of_month = dom8_q;
  assign out_o.weekday      = wd8_q;
  assign out_o.hour_value   = hv8_q;
  assign out_o.is_pm        = pm8_q;
  assign out_o.minute       = min8_q;
  assign out_o.second       = sec8_q;

  `USC_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, v7_q && !rdy7, v7_q)
  `USC_ASSERT_IMP(a_date_legal, clk_i, rst_ni, v8_q && !oor8_q, (mon8_q >= 4'd1) && (mon8_q <= 4'd12) && (dom8_q >= 5'd1) && (year8_q >= 12'd2019) && (year8_q <= 12'd2099))
  `USC_ASSERT_IMP(a_oor_zero, clk_i, rst_ni, v8_q && oor8_q, (year8_q == 12'd0) && (mon8_q == 4'd0) && (dom8_q == 5'd0) && (doy8_q == 9'd0))
  `USC_ASSERT_IMP(a_time_legal, clk_i, rst_ni, v8_q, (min8_q <= 6'd59) && (sec8_q <= 6'd59) && (hv8_q <= 5'd23) && (wd8_q <= 3'd6))

endmodule

>>> hw/rtl/unix_seconds_to_calendar.sv
// Throughput: one word per cycle while the output is ready; eight stages, each a
// constant-reciprocal multiply or a remainder / compare step, with a valid bit per stage.
// A stalled output stalls only the stages behind occupied ones; empty stages still fill.
// Reset (async, active low) empties the pipeline and sets zone offset 0, 24-hour form.
`timescale 1ns / 1ps

module unix_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  usc_in_if.sink      in_i,
  usc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  usc_pkg::usc_cfg_t   cfg;
  logic                front_valid;
  logic                front_ready;
  usc_pkg::usc_front_t front_data;

  usc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  usc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_i          (in_i),
    .front_valid_o (front_valid),
    .front_data_o  (front_data),
    .front_ready_i (front_ready)
  );

  usc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .front_valid_i (front_valid),
    .front_data_i  (front_data),
    .front_ready_o (front_ready),
    .out_o         (out_o)
  );

endmodule

>>> tb/unix_seconds_to_calendar_tb.sv
// Self-checking testbench of the UNIX seconds to calendar converter.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_tb;

  localparam longint WinStart = 64'sd1546300800;  // 2019-01-01 00:00:00
  localparam longint WinEnd   = 64'sd4102444800;  // 2100-01-01 00:00:00
  localparam longint DaySecs  = 64'sd86400;
  localparam logic [2:0] ZoneAddr   = {usc_pkg::RegZone, 2'b00};
  localparam logic [2:0] FormatAddr = {usc_pkg::RegFormat, 2'b00};
  localparam int NumPhases = 8;
  localparam int RandPerPhase = 215;

  typedef struct packed {
    logic        oor;
    logic [11:0] year;
    logic [8:0]  yday;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic        pm;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  usc_in_if  in_bus ();
  usc_out_if out_bus ();

  unix_seconds_to_calendar uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  logic [31:0]       pending_secs[$];
  cal_word_t         cal_expected[$];
  cal_word_t         want_w;
  logic signed [4:0] zone_cfg;
  logic              fmt24_cfg;
  logic signed [4:0] zone_plan[NumPhases] = '{0, 14, -12, -16, 15, 5, 0, 0};
  logic              fmt_plan[NumPhases]  = '{0, 1, 0, 1, 0, 1, 0, 1};

  int   errors, words_in, words_out, oor_seen;
  logic in_took;
  logic no_idle, long_hold_req, long_hold_done;
  logic drv_valid;
  int   send_gap, stall_gap, hold_left;

  function automatic int month_days(input int mo, input bit lp);
    case (mo)
      2:              return lp ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // Local seconds at the given day (0-based) and second of day of year y.
  function automatic longint stamp_local(input int y, input int d0, input int sod);
    longint t;
    int yy;
    t = WinStart;
    for (yy = 2019; yy < y; yy++) t += longint'((yy % 4 == 0) ? 366 : 365) * DaySecs;
    return t + longint'(d0) * DaySecs + longint'(sod);
  endfunction

  function automatic cal_word_t to_calendar(input logic [31:0] secs,
                                            input logic signed [4:0] zone,
                                            input logic fmt24);
    cal_word_t w;
    longint loc_s, day_cnt, sod;
    int yr, dleft, mo, ylen, h24;
    w = '0;
    loc_s = longint'(secs) + longint'(zone) * 3600;
    if (loc_s < WinStart || loc_s >= WinEnd) begin
      w.oor = 1'b1;
      return w;
    end
    day_cnt = (loc_s - WinStart) / DaySecs;
    sod     = (loc_s - WinStart) % DaySecs;
    w.wday  = 3'((day_cnt + 1) % 7);  // 2019-01-01 was a Tuesday
    yr = 2019;
    dleft = int'(day_cnt);
    ylen = 365;
    while (dleft >= ylen) begin
      dleft -= ylen;
      yr++;
      ylen = (yr % 4 == 0) ? 366 : 365;
    end
    w.year = 12'(yr);
    w.yday = 9'(dleft + 1);
    mo = 1;
    while (dleft >= month_days(mo, yr % 4 == 0)) begin
      dleft -= month_days(mo, yr % 4 == 0);
      mo++;
    end
    w.month  = 4'(mo);
    w.mday   = 5'(dleft + 1);
    h24      = int'(sod / 3600);
    w.pm     = (h24 >= 12);
    w.minute = 6'((sod / 60) % 60);
    w.second = 6'(sod % 60);
    if (fmt24)         w.hour = 5'(h24);
    else if (h24 == 0) w.hour = 5'd12;
    else if (h24 > 12) w.hour = 5'(h24 - 12);
    else               w.hour = 5'(h24);
    return w;
  endfunction

  // Mix of raw words, window edges, month/day edges and plain in-window times.
  function automatic logic [31:0] pick_seconds(input logic signed [4:0] zone);
    longint loc_s;
    int sel, y, mo, m, d0, sod;
    bit lp;
    sel = $urandom_range(0, 99);
    if (sel < 20) return $urandom();
    if (sel < 35) begin
      loc_s = ($urandom_range(0, 1) ? WinEnd : WinStart)
              + longint'($urandom_range(0, 180000)) - 64'sd90000;
    end else if (sel < 65) begin
      y  = $urandom_range(2019, 2099);
      lp = (y % 4 == 0);
      mo = $urandom_range(1, 12);
      d0 = 0;
      for (m = 1; m < mo; m++) d0 += month_days(m, lp);
      case ($urandom_range(0, 2))
        0:       d0 += 0;
        1:       d0 += month_days(mo, lp) - 1;
        default: d0 += $urandom_range(0, month_days(mo, lp) - 1);
      endcase
      case ($urandom_range(0, 5))
        0:       sod = 0;
        1:       sod = 86399;
        2:       sod = 43199;
        3:       sod = 43200;
        4:       sod = 3599;
        default: sod = $urandom_range(0, 86399);
      endcase
      loc_s = stamp_local(y, d0, sod);
    end else begin
      loc_s = WinStart + longint'($urandom_range(0, 32'd2556143999));
    end
    return 32'(loc_s - longint'(zone) * 3600);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_regs(input logic signed [4:0] zone, input logic fmt24);
    logic [31:0] rd;
    apb_access(1'b1, ZoneAddr, {27'b0, zone}, rd);
    zone_cfg = zone;
    apb_access(1'b1, FormatAddr, {31'b0, fmt24}, rd);
    fmt24_cfg = fmt24;
    apb_access(1'b0, ZoneAddr, '0, rd);
    check_field("zone_offset_hours readback", {27'b0, zone}, {27'b0, rd[4:0]});
    apb_access(1'b0, FormatAddr, '0, rd);
    check_field("hour_format_24 readback", {31'b0, fmt24}, {31'b0, rd[0]});
  endtask

  task automatic wait_drained();
    while (pending_secs.size() != 0 || in_bus.valid || cal_expected.size() != 0)
      @(negedge clk_i);
  endtask

  // Sender: one word held until taken, random idle bursts in between.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      drv_valid = in_bus.valid && !in_took;
      if (!drv_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_secs.size() > 0) begin
          if (!no_idle && $urandom_range(0, 4) == 0) begin
            send_gap <= $urandom_range(0, 3);
          end else begin
            in_bus.unix_seconds <= pending_secs.pop_front();
            drv_valid = 1'b1;
          end
        end
      end
      in_bus.valid <= drv_valid;
    end
  end

  // Receiver: random stall bursts plus one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        hold_left      <= 59;
        long_hold_done <= 1'b1;
        out_bus.ready  <= 1'b0;
      end else if (stall_gap > 0) begin
        stall_gap     <= stall_gap - 1;
        out_bus.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        stall_gap     <= $urandom_range(0, 3);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        cal_expected.push_back(to_calendar(in_bus.unix_seconds, zone_cfg, fmt24_cfg));
        words_in++;
      end
      if (out_bus.valid && out_bus.ready) begin
        words_out++;
        if (cal_expected.size() == 0) begin
          $error("calendar word with no timestamp pending");
          errors++;
        end else begin
          want_w = cal_expected.pop_front();
          if (want_w.oor) oor_seen++;
          check_field("out_of_range", want_w.oor, out_bus.out_of_range);
          check_field("year", want_w.year, out_bus.year);
          check_field("day_of_year", want_w.yday, out_bus.day_of_year);
          check_field("month", want_w.month, out_bus.month);
          check_field("day_of_month", want_w.mday, out_bus.day_of_month);
          check_field("weekday", want_w.wday, out_bus.weekday);
          check_field("hour_value", want_w.hour, out_bus.hour_value);
          check_field("is_pm", want_w.pm, out_bus.is_pm);
          check_field("minute", want_w.minute, out_bus.minute);
          check_field("second", want_w.second, out_bus.second);
        end
      end
    end
  end

  initial begin
    int ph, n;
    logic signed [4:0] zone;
    logic fmt24;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.unix_seconds = '0;
    out_bus.ready = 1'b0;
    in_took = 1'b0;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    send_gap = 0;
    stall_gap = 0;
    hold_left = 0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    oor_seen = 0;
    zone_cfg = '0;
    fmt24_cfg = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      zone  = zone_plan[ph];
      fmt24 = fmt_plan[ph];
      if (ph == 6) begin
        zone  = 5'($urandom_range(0, 31));
        fmt24 = 1'($urandom_range(0, 1));
      end
      program_regs(zone, fmt24);
      no_idle = (ph == 5) || (ph == NumPhases - 1);
      if (ph == 0) begin
        // zone 0, twelve-hour form: window edges, leap days, 12/24-hour corners
        pending_secs.push_back(32'h0000_0000);
        pending_secs.push_back(32'hFFFF_FFFF);
        pending_secs.push_back(32'(WinStart - 1));
        pending_secs.push_back(32'(WinStart));
        pending_secs.push_back(32'(WinEnd - 1));
        pending_secs.push_back(32'(WinEnd));
        pending_secs.push_back(32'(stamp_local(2020, 58, 86399)));
        pending_secs.push_back(32'(stamp_local(2020, 59, 0)));
        pending_secs.push_back(32'(stamp_local(2020, 60, 0)));
        pending_secs.push_back(32'(stamp_local(2020, 365, 43200)));
        pending_secs.push_back(32'(stamp_local(2021, 59, 3600)));
        pending_secs.push_back(32'(stamp_local(2019, 364, 46800)));
        pending_secs.push_back(32'(stamp_local(2019, 180, 43199)));
        pending_secs.push_back(32'(stamp_local(2096, 59, 0)));
        pending_secs.push_back(32'(stamp_local(2099, 0, 0)));
        pending_secs.push_back(32'h8000_0000);
        pending_secs.push_back(32'h7FFF_FFFF);
        pending_secs.push_back(32'h5555_5555);
        pending_secs.push_back(32'hAAAA_AAAA);
      end else begin
        for (n = 0; n < RandPerPhase; n++) pending_secs.push_back(pick_seconds(zone));
      end
      if (ph == 5) long_hold_req = 1'b1;
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    $display("Converted %0d timestamps under %0d zone/format settings, offsets -16..15h,",
             words_out, NumPhases);
    $display("both hour forms; %0d fell outside the 2019-2099 window.", oor_seen);
    if (errors == 0 && words_in == words_out) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/usc_pkg.sv
hw/rtl/usc_in_if.sv
hw/rtl/usc_out_if.sv
hw/rtl/usc_apb_regs.sv
hw/rtl/usc_front.sv
hw/rtl/usc_back.sv
hw/rtl/unix_seconds_to_calendar.sv
tb/unix_seconds_to_calendar_tb.sv
